// ----- hw/rtl/hmi_pkg.sv -----
// Shared constants and types for the hyperbolic moveout index unit.
package hmi_pkg;

  // Default sizes of the trace, offset and velocity grids.
  localparam int DefMaxSamples    = 1024;
  localparam int DefMaxOffsets    = 256;
  localparam int DefMaxVelocities = 256;

  // Field widths.
  localparam int SampleW   = 10;
  localparam int TimeW     = 24;
  localparam int OffsetW   = 16;
  localparam int OffIdxW   = 8;
  localparam int VelIdxW   = 8;
  localparam int VelSqW    = 30;
  localparam int IntervalW = 16;
  localparam int CountW    = 11;
  localparam int IndexW    = 18;
  localparam int InDataW   = 96;
  localparam int OutDataW  = 40;
  localparam int CfgAddrW  = 2;
  localparam int CfgDataW  = 16;

  // Quotient bits resolved per divider stage.
  localparam int DivStep = 2;

  // Fixed-point scaling.
  localparam logic [19:0] MicroScale  = 20'd1000000;
  localparam logic [60:0] MoveCap     = 61'h1000_0000_0000_0000;
  // The cap applies once the quotient reaches floor(2^60 / 10^6) * 10^6.
  localparam logic [59:0] MoveSatFrom = 60'd1152921504606000000;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] CfgSampleInterval = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgNumSamples     = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgFirstSample    = 2'd2;

  localparam logic [IntervalW-1:0] RstSampleInterval = 16'd4000;
  localparam logic [CountW-1:0]    RstNumSamples     = 11'd1024;
  localparam logic [SampleW-1:0]   RstFirstSample    = 10'd0;

  // Bookkeeping that rides along with an item through the arithmetic units.
  typedef struct packed {
    logic               pass;
    logic [SampleW-1:0] sample;
    logic [OffIdxW-1:0] off_idx;
    logic [VelIdxW-1:0] vel_idx;
  } idx_info_t;

endpackage

// ----- hw/rtl/hmi_div_pipe.sv -----
// Pipelined restoring divider with a side payload, a few quotient bits per stage.
module hmi_div_pipe import hmi_pkg::*; #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  // NUM_W is expected to be a multiple of DivStep.
  localparam int Stages = NUM_W / DivStep;

  logic              valid_q [Stages];
  logic [DEN_W-1:0]  rem_q   [Stages];
  logic [NUM_W-1:0]  nq_q    [Stages];
  logic [DEN_W-1:0]  den_q   [Stages];
  logic [SIDE_W-1:0] side_q  [Stages];

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    logic              valid_in;
    logic [DEN_W-1:0]  rem_in, rem_nx, den_in;
    logic [NUM_W-1:0]  nq_in, nq_nx;
    logic [SIDE_W-1:0] side_in;

    if (g == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = rem_i;
      assign nq_in    = num_i;
      assign den_in   = den_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[g-1];
      assign rem_in   = rem_q[g-1];
      assign nq_in    = nq_q[g-1];
      assign den_in   = den_q[g-1];
      assign side_in  = side_q[g-1];
    end

    // The dividend shifts out at the top while quotient bits fill in at the bottom.
    always_comb begin
      logic [DEN_W:0] trial;
      rem_nx = rem_in;
      nq_nx  = nq_in;
      trial  = '0;
      for (int k = 0; k < DivStep; k++) begin
        trial = {rem_nx, nq_nx[NUM_W-1]};
        nq_nx = {nq_nx[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          trial    = trial - {1'b0, den_in};
          nq_nx[0] = 1'b1;
        end
        rem_nx = trial[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_nx;
        nq_q[g]   <= nq_nx;
        den_q[g]  <= den_in;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign quo_o   = nq_q[Stages-1];
  assign side_o  = side_q[Stages-1];

endmodule

// ----- hw/rtl/hmi_sqrt_pipe.sv -----
// Pipelined integer square root, one root bit per stage, with a side payload.
module hmi_sqrt_pipe import hmi_pkg::*; #(
  parameter int IN_W   = 62,
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [IN_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int RootW = IN_W / 2;
  localparam int RemW  = RootW + 2;

  logic              valid_q [RootW];
  logic [RemW-1:0]   rem_q   [RootW];
  logic [RootW-1:0]  root_q  [RootW];
  logic [IN_W-1:0]   rad_q   [RootW];
  logic [SIDE_W-1:0] side_q  [RootW];

  for (genvar g = 0; g < RootW; g++) begin : g_stage
    logic              valid_in;
    logic [RemW-1:0]   rem_in, rem_nx;
    logic [RootW-1:0]  root_in, root_nx;
    logic [IN_W-1:0]   rad_in, rad_nx;
    logic [SIDE_W-1:0] side_in;

    if (g == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign rad_in   = rad_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[g-1];
      assign rem_in   = rem_q[g-1];
      assign root_in  = root_q[g-1];
      assign rad_in   = rad_q[g-1];
      assign side_in  = side_q[g-1];
    end

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
      logic [RemW+1:0] acc;
      logic [RemW+1:0] trial;
      acc    = {rem_in, rad_in[IN_W-1:IN_W-2]};
      trial  = {2'b00, root_in, 2'b01};
      rad_nx = {rad_in[IN_W-3:0], 2'b00};
      if (acc >= trial) begin
        acc     = acc - trial;
        root_nx = {root_in[RootW-2:0], 1'b1};
      end else begin
        root_nx = {root_in[RootW-2:0], 1'b0};
      end
      rem_nx = acc[RemW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_nx;
        root_q[g] <= root_nx;
        rad_q[g]  <= rad_nx;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

// ----- hw/rtl/hyperbolic_moveout_index_unit.sv -----
// Top level of the hyperbolic moveout index unit.
//
// Each request on the slave stream carries one (sample, time, offset, velocity)
// triple. The unit forms T = sqrt(t^2 + 4*h^2*10^12/v^2), rounds T by the sample
// interval to a moveout sample and, when that sample lies inside the trace,
// sends one request on the master stream with the data and model indexes.
// Triples that fall outside the trace or the grid produce nothing.
// Configuration writes go through the cfg channel, which is always ready. The user must
// make them only while the unit holds no triple in flight; the unit does not enforce it.
// Between acceptance and its result in the output register a triple passes four
// front stages, a 30-stage divider for the moveout term, one sum stage, a 31-stage
// square root, one rounding stage, a 16-stage divider by the interval and the output
// register. One triple is taken every cycle while the pipeline is not held.
// When the receiver stalls with the output register full, the whole pipeline
// holds and s_axis_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the interval 4000, the sample count
// 1024 and the first sample 0.
module hyperbolic_moveout_index_unit import hmi_pkg::*; #(
  parameter int MAX_SAMPLES    = DefMaxSamples,
  parameter int MAX_OFFSETS    = DefMaxOffsets,
  parameter int MAX_VELOCITIES = DefMaxVelocities
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // sample_index[9:0], time_value[33:10], offset[49:34], offset_index[57:50],
  // velocity_index[65:58], velocity_squared[95:66]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // data_index[17:0], model_index[35:18], zero fill[39:36]
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int Div1Side = TimeW * 2 + 2 + $bits(idx_info_t);
  localparam int InfoW    = $bits(idx_info_t);

  // Configuration registers.
  logic [IntervalW-1:0] interval_q;
  logic [CountW-1:0]    count_q;
  logic [SampleW-1:0]   first_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= RstSampleInterval;
      count_q    <= RstNumSamples;
      first_q    <= RstFirstSample;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CfgSampleInterval: interval_q <= cfg_data_i;
        CfgNumSamples:     count_q    <= cfg_data_i[CountW-1:0];
        CfgFirstSample:    first_q    <= cfg_data_i[SampleW-1:0];
        default: ;
      endcase
    end
  end

  logic [CountW-1:0]    ns_eff;
  logic [IntervalW-1:0] dt_eff;

  assign ns_eff = ({21'd0, count_q} > 32'(MAX_SAMPLES)) ? CountW'(MAX_SAMPLES) : count_q;
  assign dt_eff = (interval_q == '0) ? IntervalW'(1) : interval_q;

  // The pipeline moves as a whole unless a finished result is waiting.
  logic out_valid_q;
  logic en;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Input unpacking.
  logic [SampleW-1:0] in_sample;
  logic [TimeW-1:0]   in_time;
  logic [OffsetW-1:0] in_offset;
  logic [OffIdxW-1:0] in_off_idx;
  logic [VelIdxW-1:0] in_vel_idx;
  logic [VelSqW-1:0]  in_vel_sq;
  idx_info_t          in_info;

  assign in_sample  = s_axis_tdata[9:0];
  assign in_time    = s_axis_tdata[33:10];
  assign in_offset  = s_axis_tdata[49:34];
  assign in_off_idx = s_axis_tdata[57:50];
  assign in_vel_idx = s_axis_tdata[65:58];
  assign in_vel_sq  = s_axis_tdata[95:66];

  always_comb begin
    in_info.pass    = (in_sample >= first_q) && ({1'b0, in_sample} < ns_eff)
                      && ({24'd0, in_off_idx} < 32'(MAX_OFFSETS))
                      && ({24'd0, in_vel_idx} < 32'(MAX_VELOCITIES));
    in_info.sample  = in_sample;
    in_info.off_idx = in_off_idx;
    in_info.vel_idx = in_vel_idx;
  end

  // Stage A: operand capture and offset magnitude.
  logic               a_valid_q;
  idx_info_t          a_info_q;
  logic [OffsetW-1:0] a_mag_q;
  logic [TimeW-1:0]   a_time_q;
  logic [VelSqW-1:0]  a_vsq_q;

  // Stage B: squares.
  logic               b_valid_q;
  idx_info_t          b_info_q;
  logic [30:0]        b_h2_q;
  logic [2*TimeW-1:0] b_tsq_q;
  logic [VelSqW-1:0]  b_vsq_q;

  // Stage C: h^2 * 10^6.
  logic               c_valid_q;
  idx_info_t          c_info_q;
  logic [50:0]        c_prod_q;
  logic               c_hzero_q;
  logic [2*TimeW-1:0] c_tsq_q;
  logic [VelSqW-1:0]  c_vsq_q;

  // Stage D: h^2 * 10^12.
  logic               d_valid_q;
  idx_info_t          d_info_q;
  logic [69:0]        d_prod_q;
  logic               d_hzero_q;
  logic [2*TimeW-1:0] d_tsq_q;
  logic [VelSqW-1:0]  d_vsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= s_axis_tvalid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_info_q  <= in_info;
      a_mag_q   <= in_offset[OffsetW-1] ? OffsetW'(~in_offset + 1'b1) : in_offset;
      a_time_q  <= in_time;
      a_vsq_q   <= in_vel_sq;

      b_info_q  <= a_info_q;
      b_h2_q    <= 31'(a_mag_q * a_mag_q);
      b_tsq_q   <= (2*TimeW)'(a_time_q * a_time_q);
      b_vsq_q   <= a_vsq_q;

      c_info_q  <= b_info_q;
      c_prod_q  <= 51'(b_h2_q * MicroScale);
      c_hzero_q <= (b_h2_q == '0);
      c_tsq_q   <= b_tsq_q;
      c_vsq_q   <= b_vsq_q;

      d_info_q  <= c_info_q;
      d_prod_q  <= 70'(c_prod_q * MicroScale);
      d_hzero_q <= c_hzero_q;
      d_tsq_q   <= c_tsq_q;
      d_vsq_q   <= c_vsq_q;
    end
  end

  // Moveout term: floor(4 * h^2 * 10^12 / v^2) over 60 quotient bits. The top bits
  // of the dividend seed the remainder; a quotient from MoveSatFrom up saturates to 2^60.
  logic [71:0]         d_num;
  logic                d_over;
  logic [Div1Side-1:0] div1_side_in, div1_side_out;
  logic                div1_valid;
  logic [59:0]         div1_quo;

  assign d_num        = {d_prod_q, 2'b00};
  assign d_over       = {18'd0, d_num[71:60]} >= d_vsq_q;
  assign div1_side_in = {d_tsq_q, d_hzero_q, d_over, d_info_q};

  hmi_div_pipe #(
    .NUM_W  (60),
    .DEN_W  (VelSqW),
    .SIDE_W (Div1Side)
  ) u_move_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid_q),
    .rem_i   ({18'd0, d_num[71:60]}),
    .num_i   (d_num[59:0]),
    .den_i   (d_vsq_q),
    .side_i  (div1_side_in),
    .valid_o (div1_valid),
    .quo_o   (div1_quo),
    .side_o  (div1_side_out)
  );

  logic [2*TimeW-1:0] f_tsq;
  logic               f_hzero;
  logic               f_over;
  idx_info_t          f_info;
  logic [60:0]        f_move;

  assign {f_tsq, f_hzero, f_over, f_info} = div1_side_out;

  always_comb begin
    if (f_hzero) begin
      f_move = '0;
    end else if (f_over || (div1_quo >= MoveSatFrom)) begin
      f_move = MoveCap;
    end else begin
      f_move = {1'b0, div1_quo};
    end
  end

  // Stage F: t^2 plus the moveout term.
  logic        f_valid_q;
  idx_info_t   f_info_q;
  logic [60:0] f_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= div1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_info_q <= f_info;
      f_sum_q  <= {13'd0, f_tsq} + f_move;
    end
  end

  logic             sqrt_valid;
  logic [30:0]      sqrt_root;
  logic [InfoW-1:0] sqrt_side;

  hmi_sqrt_pipe #(
    .IN_W   (62),
    .SIDE_W (InfoW)
  ) u_time_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid_q),
    .rad_i   ({1'b0, f_sum_q}),
    .side_i  (f_info_q),
    .valid_o (sqrt_valid),
    .root_o  (sqrt_root),
    .side_o  (sqrt_side)
  );

  // Stage H: add half an interval for rounding.
  logic             h_valid_q;
  logic [InfoW-1:0] h_info_q;
  logic [31:0]      h_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
    end else if (en) begin
      h_valid_q <= sqrt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_info_q <= sqrt_side;
      h_num_q  <= {1'b0, sqrt_root} + {17'd0, dt_eff[IntervalW-1:1]};
    end
  end

  logic             div2_valid;
  logic [31:0]      div2_quo;
  logic [InfoW-1:0] div2_side;

  hmi_div_pipe #(
    .NUM_W  (32),
    .DEN_W  (IntervalW),
    .SIDE_W (InfoW)
  ) u_round_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h_valid_q),
    .rem_i   ('0),
    .num_i   (h_num_q),
    .den_i   (dt_eff),
    .side_i  (h_info_q),
    .valid_o (div2_valid),
    .quo_o   (div2_quo),
    .side_o  (div2_side)
  );

  // Output stage: range check on the moveout sample and index formation.
  idx_info_t   o_info;
  logic        o_fits;
  logic [19:0] o_data_sum;
  logic [19:0] o_model_sum;

  assign o_info      = div2_side;
  assign o_fits      = div2_quo < {21'd0, ns_eff};
  assign o_data_sum  = 20'(o_info.off_idx * ns_eff) + {9'd0, div2_quo[CountW-1:0]};
  assign o_model_sum = 20'(o_info.vel_idx * ns_eff) + {10'd0, o_info.sample};

  logic [IndexW-1:0] data_idx_q;
  logic [IndexW-1:0] model_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div2_valid && o_info.pass && o_fits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_idx_q  <= o_data_sum[IndexW-1:0];
      model_idx_q <= o_model_sum[IndexW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, model_idx_q, data_idx_q};

endmodule

// ----- tb/hmi_checker.sv -----
// Checker for the hyperbolic moveout index unit: predicts and compares results.
`timescale 1ns / 1ps
module hmi_checker import hmi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  results_o
);

  // Laid out as on the bus: data index in the low bits.
  typedef struct packed {
    logic [IndexW-1:0] model_idx;
    logic [IndexW-1:0] data_idx;
  } index_pair_t;

  logic [IntervalW-1:0] interval_q;
  logic [CountW-1:0]    count_q;
  logic [SampleW-1:0]   first_q;
  index_pair_t          pair_q[$];

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Returns 1 and the index pair when the triple lands inside the trace.
  function automatic bit moveout_pair(input logic [InDataW-1:0] d, output index_pair_t p);
    logic [63:0] smp, t, mag, h2, v2, a, q1, r1, term, root, dt, ns, itime, cap;
    smp = 64'(d[9:0]);
    t = 64'(d[33:10]);
    mag = d[49] ? 64'h10000 - 64'(d[49:34]) : 64'(d[49:34]);
    v2 = 64'(d[95:66]);
    cap = 64'(MoveCap);
    ns = (64'(count_q) > 64'(DefMaxSamples)) ? 64'(DefMaxSamples) : 64'(count_q);
    dt = (interval_q == '0) ? 64'd1 : 64'(interval_q);
    p = '0;
    if (smp < 64'(first_q) || smp >= ns) return 0;
    h2 = mag * mag;
    if (h2 == 0) term = 0;
    else if (v2 == 0) term = cap;
    else begin
      a = (h2 << 2) * 64'd1000000;
      q1 = a / v2;
      r1 = a % v2;
      if (q1 >= (cap / 64'd1000000)) term = cap;
      else begin
        term = q1 * 64'd1000000 + (r1 * 64'd1000000) / v2;
        if (term > cap) term = cap;
      end
    end
    root = isqrt64(t * t + term);
    itime = (root + (dt >> 1)) / dt;
    if (itime >= ns) return 0;
    p.data_idx = IndexW'(64'(d[57:50]) * ns + itime);
    p.model_idx = IndexW'(64'(d[65:58]) * ns + smp);
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input logic [IndexW-1:0] got,
                                 input logic [IndexW-1:0] want);
    $display("%0t: mismatch %s got %0d expected %0d", $time, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    results_o = 0;
  end

  assign pending_o = pair_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    index_pair_t p;
    index_pair_t got;
    if (!rst_ni) begin
      interval_q <= RstSampleInterval;
      count_q <= RstNumSamples;
      first_q <= RstFirstSample;
      pair_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          CfgSampleInterval: interval_q <= cfg_data_i;
          CfgNumSamples: count_q <= cfg_data_i[CountW-1:0];
          CfgFirstSample: first_q <= cfg_data_i[SampleW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i && moveout_pair(s_tdata_i, p)) pair_q.push_back(p);
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[2*IndexW-1:0];
        results_o++;
        if (pair_q.size() == 0) begin
          report_mismatch("unexpected result", got.data_idx, '0);
        end else begin
          p = pair_q.pop_front();
          if (got.data_idx !== p.data_idx) report_mismatch("data_index", got.data_idx, p.data_idx);
          if (got.model_idx !== p.model_idx) begin
            report_mismatch("model_index", got.model_idx, p.model_idx);
          end
          if (m_tdata_i[OutDataW-1:2*IndexW] !== '0) report_mismatch("zero fill", 0, 0);
        end
      end
    end
  end

endmodule

// ----- tb/tb_hyperbolic_moveout_index_unit.sv -----
// Top of the testbench for the hyperbolic moveout index unit: stimulus and verdict.
`timescale 1ns / 1ps
module tb_hyperbolic_moveout_index_unit;
  import hmi_pkg::*;

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                cfg_valid_i = 0;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 0;
  logic [OutDataW-1:0] m_axis_tdata;
  int errors, pending, results;
  int triples_sent = 0;
  bit rx_steady = 0;

  hyperbolic_moveout_index_unit DUT (.*);

  hmi_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_addr_i, .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] value);
    cfg_addr_i <= addr;
    cfg_data_i <= value;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  // The valid line stays high between back-to-back requests and drops only for idling or draining.
  task automatic send_triple(input logic [InDataW-1:0] d, input bit may_idle);
    if (may_idle && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tdata <= d;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    triples_sent++;
  endtask

  function automatic logic [InDataW-1:0] pack_triple(input logic [9:0] smp,
      input logic [23:0] t, input logic [15:0] off, input logic [7:0] oi,
      input logic [7:0] vi, input logic [29:0] v2);
    return {v2, vi, oi, off, t, smp};
  endfunction

  // Mostly triples near the trace with realistic velocities; some raw noise.
  function automatic logic [InDataW-1:0] random_triple(input int ns, input int dt);
    logic [InDataW-1:0] d;
    logic [29:0] vel;
    if ($urandom_range(0, 7) == 0) begin
      d = {$urandom, $urandom, $urandom};
    end else begin
      vel = 30'($urandom_range(1000, 6000));
      d = pack_triple(10'($urandom_range(0, ns - 1)), 24'($urandom_range(0, ns * dt)),
                      16'($urandom_range(0, 65535)), 8'($urandom), 8'($urandom),
                      vel * vel);
      if ($urandom_range(0, 3) == 0) d[95:66] = 30'($urandom);
      if ($urandom_range(0, 3) == 0) d[49:34] = 16'($urandom_range(0, 300));
    end
    return d;
  endfunction

  // Receiver stalls in bursts until the steady tail.
  always begin
    @(negedge clk_i);
    if (rx_steady || $urandom_range(0, 3) != 0) begin
      m_axis_tready <= 1;
      if (!rx_steady) repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end else begin
      m_axis_tready <= 0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
  end

  initial begin
    #8000000;
    $display("FAIL hyperbolic_moveout_index_unit");
    $finish;
  end

  initial begin
    int dts[4] = '{4000, 1, 65535, 0};
    int nss[4] = '{1024, 1, 2047, 300};
    int fss[4] = '{0, 0, 1023, 5};
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // Directed corners under reset settings.
    send_triple(pack_triple(0, 0, 0, 0, 0, 1), 0);
    send_triple(pack_triple(1023, 24'hFFFFFF, 16'h8000, 255, 255, 30'h3FFFFFFF), 0);
    send_triple(pack_triple(10, 40000, 16'h7FFF, 3, 4, 0), 0);
    send_triple(pack_triple(10, 40000, 0, 3, 4, 0), 0);
    send_triple(pack_triple(100, 400000, 16'hFC18, 255, 255, 4000000), 0);
    send_triple(pack_triple(500, 2000000, 1000, 7, 9, 9000000), 0);
    send_triple(pack_triple(1023, 4092000, 0, 255, 255, 1), 0);
    send_triple(pack_triple(1023, 4094000, 0, 1, 1, 1), 0);
    send_triple(pack_triple(2, 8000, 16'hFFFF, 0, 1, 1), 0);
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      int dt, ns;
      if (ph > 0) begin
        write_reg(CfgSampleInterval, CfgDataW'(dts[ph - 1]));
        write_reg(CfgNumSamples, CfgDataW'(nss[ph - 1]));
        write_reg(CfgFirstSample, CfgDataW'(fss[ph - 1]));
        if (ph == 4) write_reg(CfgSampleInterval, 1000);
      end
      dt = (ph == 0 || ph == 1) ? 4000 : (ph == 2) ? 1 : (ph == 3) ? 65535 : 1000;
      ns = (ph == 2) ? 1 : (ph == 3) ? 1024 : (ph == 4) ? 300 : 1024;
      if (ph == 1) ns = 1024;
      if (ph == 4) rx_steady = 1;
      for (int k = 0; k < 230; k++) begin
        send_triple(random_triple(ns, dt), !rx_steady);
        if (ph == 0 && k == 100) wait_drained();
      end
      wait_drained();
    end
    $display("Sent %0d triples over five register settings; %0d index pairs checked.",
             triples_sent, results);
    if (errors == 0) begin
      $display("PASS hyperbolic_moveout_index_unit");
    end else begin
      $display("FAIL hyperbolic_moveout_index_unit");
    end
    $finish;
  end

endmodule

// ----- hyperbolic_moveout_index_unit.f -----
hw/rtl/hmi_pkg.sv
hw/rtl/hmi_div_pipe.sv
hw/rtl/hmi_sqrt_pipe.sv
hw/rtl/hyperbolic_moveout_index_unit.sv
tb/hmi_checker.sv
tb/tb_hyperbolic_moveout_index_unit.sv
